// File: src/srtr_pkg.sv
// Shared types and constants for the sample ring threshold/rms unit.
package srtr_pkg;

	localparam int RING_DEPTH  = 256;
	localparam int SAMPLE_BITS = 24;

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	// square of a magnitude, and a sum of RING_DEPTH of them
	localparam int SQ_W   = 2 * SAMPLE_BITS;
	localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + ADDR_W;
	// shared subtractor width, sized for the square-root remainder
	localparam int SUB_W  = SAMPLE_BITS + 3;
	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_EVENTS = 2'd1;
	localparam logic [1:0] MODE_RMS    = 2'd2;

	typedef struct packed {
		logic [1:0]                    mode;
		logic signed [SAMPLE_BITS-1:0] new_sample;
		logic [CNT_W-1:0]              span;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]       event_count;
		logic [SAMPLE_BITS-1:0] rms_value;
		logic [CNT_W-1:0]       stored_count;
	} out_item_t;

	typedef logic [SAMPLE_BITS-1:0] thresh_t;

endpackage

// File: src/srtr_ifs.sv
// Valid/ready channel interfaces: request, response and threshold write.
interface srtr_in_if import srtr_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srtr_out_if import srtr_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface srtr_cfg_if import srtr_pkg::*; ();
	logic    valid;
	logic    ready;
	thresh_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/sample_ring_threshold_rms_unit.sv
// Sample ring with windowed threshold event count and integer rms, one shared subtractor.
//
//  channel | dir | payload                              | transaction
//  --------+-----+--------------------------------------+------------------------
//  req     | in  | mode, new_sample, span               | req.valid & req.ready
//  rsp     | out | event_count, rms_value, stored_count | rsp.valid & rsp.ready
//  cfg     | in  | threshold                            | cfg.valid & cfg.ready
//
// A push writes one ring entry. A query walks the newest n = min(span, fill)
// entries; the window walk reads one ring entry per cycle through the single
// memory read port, then for an rms query the divide and the square root each
// take one bit (two for the root) per step on the shared subtractor. req is not
// ready while an item is in work. A finished result sits in the rsp register;
// the next request is taken while it waits, and the sequencer holds at its final
// step only if the register is still full. Reset clears pointer, fill count and
// threshold; the ring needs no clearing.
module sample_ring_threshold_rms_unit import srtr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	srtr_in_if.sink     req,
	srtr_out_if.source  rsp,
	srtr_cfg_if.sink    cfg
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_WALK = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SQRT = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;

	logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];

	thresh_t             thresh_q;
	logic [ADDR_W-1:0]   wp_q;
	logic [CNT_W-1:0]    fill_q;
	logic [1:0]          mode_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    issue_left_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic [SQ_W-1:0]     sq_s2;
	logic                hit_s2;
	logic                vld_s2;
	logic [SUM_W-1:0]    acc_q;
	logic [CNT_W-1:0]    evt_q;
	logic [SUM_W-1:0]    div_q;
	logic [CNT_W-1:0]    rem_q;
	logic [SQ_W-1:0]     rad_q;
	logic [SAMPLE_BITS-1:0] root_q;
	logic [SUB_W-1:0]    srem_q;
	logic [STEP_W-1:0]   step_q;
	out_item_t           out_q;
	logic                out_vld_q;

	logic                req_acc;
	logic                rsp_acc;
	logic                push_we;
	logic                rd_en;
	logic                walk_done;
	logic                out_load;
	logic [CNT_W-1:0]    win_n;
	logic [SAMPLE_BITS-1:0] mag_s1;

	// shared subtractor
	logic [SUB_W-1:0]    sub_a;
	logic [SUB_W-1:0]    sub_b;
	logic [SUB_W:0]      sub_d;
	logic                sub_ge;
	logic [SUM_W-1:0]    div_next;

	assign req_acc   = req.valid && req.ready;
	assign rsp_acc   = rsp.valid && rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	assign push_we  = req_acc && (req.data.mode == MODE_PUSH);
	assign win_n    = (req.data.span < fill_q) ? req.data.span : fill_q;
	assign rd_en    = (state_q == ST_WALK) && (issue_left_q != '0);
	assign walk_done = (issue_left_q == '0) && !rd_vld_s1 && !vld_s2;
	assign out_load = (state_q == ST_FIN) && (!out_vld_q || rsp.ready);

	assign mag_s1 = rd_data_s1[SAMPLE_BITS-1] ? (~rd_data_s1 + SAMPLE_BITS'(1)) : rd_data_s1;

	always_comb begin
		sub_a = '0;
		sub_b = '0;
		if (state_q == ST_SQRT) begin
			sub_a = {srem_q[SUB_W-3:0], rad_q[SQ_W-1 -: 2]};
			sub_b = SUB_W'({root_q, 2'b01});
		end else begin
			sub_a = SUB_W'({rem_q, div_q[SUM_W-1]});
			sub_b = SUB_W'(n_q);
		end
	end

	assign sub_d    = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge   = !sub_d[SUB_W];
	assign div_next = {div_q[SUM_W-2:0], sub_ge};

	// ring storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push_we) begin
			mem[wp_q] <= req.data.new_sample;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			thresh_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wp_q         <= '0;
			fill_q       <= '0;
			issue_left_q <= '0;
			rd_vld_s1    <= 1'b0;
			vld_s2       <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			vld_s2    <= rd_vld_s1;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_acc) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.data.mode == MODE_PUSH) begin
							state_q <= ST_FIN;
							wp_q    <= wp_q + ADDR_W'(1);
							if (fill_q != CNT_W'(RING_DEPTH)) begin
								fill_q <= fill_q + CNT_W'(1);
							end
						end else if ((req.data.mode inside {MODE_EVENTS, MODE_RMS}) &&
							win_n != '0) begin
							issue_left_q <= win_n;
							state_q      <= ST_WALK;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_WALK: begin
					if (rd_en) begin
						issue_left_q <= issue_left_q - CNT_W'(1);
					end
					if (walk_done) begin
						state_q <= (mode_q == MODE_RMS) ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (step_q == STEP_W'(SAMPLE_BITS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			sq_s2  <= mag_s1 * mag_s1;
			hit_s2 <= (mag_s1 > thresh_q);
		end
		if (out_load) begin
			// the walk counts hits in both query modes; only the event query reports them
			out_q.event_count  <= (mode_q == MODE_EVENTS) ? evt_q : '0;
			out_q.rms_value    <= root_q;
			out_q.stored_count <= fill_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					mode_q    <= req.data.mode;
					n_q       <= win_n;
					rd_addr_q <= wp_q - win_n[ADDR_W-1:0];
					acc_q     <= '0;
					evt_q     <= '0;
					root_q    <= '0;
				end
			end
			ST_WALK: begin
				if (rd_en) begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
				end
				if (vld_s2) begin
					acc_q <= acc_q + SUM_W'(sq_s2);
					evt_q <= evt_q + CNT_W'(hit_s2);
				end
				div_q  <= acc_q;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				// restoring division, quotient bits shift in behind the dividend
				div_q  <= div_next;
				rem_q  <= sub_ge ? sub_d[CNT_W-1:0] : sub_a[CNT_W-1:0];
				if (step_q == STEP_W'(SUM_W - 1)) begin
					rad_q  <= div_next[SQ_W-1:0];
					srem_q <= '0;
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			ST_SQRT: begin
				// two radicand bits per step, one root bit out
				rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
				srem_q <= sub_ge ? sub_d[SUB_W-1:0] : sub_a;
				root_q <= {root_q[SAMPLE_BITS-2:0], sub_ge};
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(RING_DEPTH))
		else $error("fill count above ring depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_we && fill_q != CNT_W'(RING_DEPTH)) |=> (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("push did not grow fill count");

	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_WALK) |-> (!rd_vld_s1 && !vld_s2))
		else $error("ring read in flight outside window walk");

	a_one_metric: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.event_count != '0) |-> (out_q.rms_value == '0))
		else $error("event count and rms both nonzero");

	a_evt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.event_count <= out_q.stored_count))
		else $error("event count above stored count");

endmodule
